### sv/srmm_pkg.sv
// Shared constants, types and codes for the sparse row matrix multiply block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package srmm_pkg;
    localparam int MAX_DIM     = 64;
    localparam int MAX_NNZ     = 1024;
    localparam int VALUE_WIDTH = 16;
    localparam int COL_W       = $clog2(MAX_DIM);
    localparam int DIM_W       = 7;
    localparam int ADDR_W      = $clog2(MAX_NNZ);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int ACC_W       = 40;
    localparam int PROD_W      = 2 * VALUE_WIDTH;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = 2;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [1:0] {
        FN_LOAD  = 2'd0,
        FN_A     = 2'd1,
        FN_EMPTY = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_B_ROWS = 1'b1;

    typedef struct packed {
        logic [1:0]                    func;
        logic [COL_W-1:0]              row_index;
        logic [COL_W-1:0]              col_index;
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          row_end;
    } t_in;

    typedef struct packed {
        logic [COL_W-1:0]        out_col;
        logic signed [ACC_W-1:0] out_value;
        logic                    last_of_row;
        logic                    row_empty;
        logic                    overflow;
    } t_out;

    // Classified operation handed from the front to the back.
    typedef struct packed {
        logic                          walk;
        logic                          emit;
        logic [ADDR_W-1:0]             first;
        logic [CNT_W-1:0]              length;
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          dropped;
    } t_op;
endpackage
`default_nettype wire

### sv/srmm_if.sv
// Valid/ready channel interfaces for input items, results and configuration.
// Depends on srmm_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface srmm_in_if;
    logic             valid;
    logic             ready;
    srmm_pkg::t_in    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface srmm_out_if;
    logic             valid;
    logic             ready;
    srmm_pkg::t_out   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface srmm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [srmm_pkg::CFG_IDX_W-1:0]     index;
    logic [srmm_pkg::CFG_DATA_W-1:0]    wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

### sv/srmm_front.sv
// Front end: accepts items, keeps the row directory, writes B into the store memory.
// Depends on srmm_pkg and srmm_if.
`timescale 1ns / 1ps
`default_nettype none
module srmm_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    srmm_in_if.sink                in_ch,
    input  wire logic [srmm_pkg::DIM_W-1:0] i_nc,
    input  wire logic [srmm_pkg::DIM_W-1:0] i_nr,
    input  wire logic              i_q_full,
    output srmm_pkg::t_op          o_op,
    output logic                   o_op_push,
    output logic                   o_b_we,
    output logic [srmm_pkg::ADDR_W-1:0] o_b_addr,
    output logic [srmm_pkg::COL_W-1:0]  o_b_col,
    output logic signed [srmm_pkg::VALUE_WIDTH-1:0] o_b_val
);
    import srmm_pkg::*;

    logic [ADDR_W-1:0]  r_first [MAX_DIM];
    logic [CNT_W-1:0]   r_len   [MAX_DIM];
    logic [MAX_DIM-1:0] r_vld;
    logic [CNT_W-1:0]   r_fill, n_fill;
    logic               r_drop, n_drop;
    logic               r_busy;
    t_in                r_it;
    logic [ADDR_W-1:0]  r_first_rd;
    logic [CNT_W-1:0]   r_len_rd;
    logic               r_vld_rd;
    logic               acc, load_ok, in_rng, a_rng;
    logic [COL_W-1:0]   rd_row;
    logic [CNT_W-1:0]   row_len;
    logic [CNT_W-1:0]   row_endp;

    // No new item while one is in hand (directory read, then classify) or the op queue is full.
    assign in_ch.ready = !r_busy && !i_q_full;
    assign acc = in_ch.valid && in_ch.ready;
    assign rd_row = (t_func'(in_ch.data.func) == FN_LOAD) ? in_ch.data.row_index
                                                          : in_ch.data.col_index;
    assign row_len  = r_vld_rd ? r_len_rd : '0;
    assign row_endp = CNT_W'(r_first_rd) + row_len;
    assign in_rng = ({1'b0, r_it.row_index} < i_nr)
                 && ({1'b0, r_it.col_index} < i_nc)
                 && (r_fill < CNT_W'(MAX_NNZ));
    assign load_ok = in_rng && ((row_len == '0) || (row_endp == r_fill));
    assign a_rng = ({1'b0, r_it.col_index} < i_nr);

    always_comb begin
        n_fill = r_fill;
        n_drop = r_drop;
        o_b_we = 1'b0;
        o_op_push = 1'b0;
        o_op = '0;
        o_op.value = r_it.value;
        o_op.first = r_first_rd;
        o_op.length = a_rng ? row_len : '0;
        o_op.dropped = r_drop;
        if (r_busy) begin
            case (t_func'(r_it.func))
                FN_LOAD: begin
                    if (load_ok) begin
                        o_b_we = 1'b1;
                        n_fill = r_fill + 1'b1;
                    end else begin
                        n_drop = 1'b1;
                    end
                end
                FN_A: begin
                    o_op.walk = 1'b1;
                    o_op.emit = r_it.row_end;
                    o_op_push = 1'b1;
                end
                FN_EMPTY: begin
                    o_op.emit = 1'b1;
                    o_op.length = '0;
                    o_op_push = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_b_addr = r_fill[ADDR_W-1:0];
    assign o_b_col  = r_it.col_index;
    assign o_b_val  = r_it.value;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_it <= in_ch.data;
            r_first_rd <= r_first[rd_row];
            r_len_rd <= r_len[rd_row];
            r_vld_rd <= r_vld[rd_row];
        end
        if (o_b_we) begin
            r_len[r_it.row_index] <= row_len + 1'b1;
            if (row_len == '0) begin
                r_first[r_it.row_index] <= r_fill[ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_drop <= 1'b0;
            r_busy <= 1'b0;
            r_vld  <= '0;
        end else begin
            r_fill <= n_fill;
            r_drop <= n_drop;
            r_busy <= acc;
            if (o_b_we) begin
                r_vld[r_it.row_index] <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

### sv/srmm_queue.sv
// Short FIFO of classified operations between the front and back ends.
// Depends on srmm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srmm_queue (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  srmm_pkg::t_op i_op,
    output logic          o_full,
    input  wire logic     i_pop,
    output logic          o_empty,
    output srmm_pkg::t_op o_op
);
    import srmm_pkg::*;

    t_op             r_mem [QDEPTH];
    logic [QPTR_W:0] r_wp, r_rp;

    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[QPTR_W] != r_rp[QPTR_W])
                  && (r_wp[QPTR_W-1:0] == r_rp[QPTR_W-1:0]);
    assign o_op = r_mem[r_rp[QPTR_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp[QPTR_W-1:0]] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
        end
    end
endmodule
`default_nettype wire

### sv/srmm_back.sv
// Back end: walks stored B rows, accumulates, scans and emits the product row.
// Holds the B store memory. Depends on srmm_pkg and srmm_if.
`timescale 1ns / 1ps
`default_nettype none
module srmm_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [srmm_pkg::DIM_W-1:0] i_nc,
    input  wire logic              i_b_we,
    input  wire logic [srmm_pkg::ADDR_W-1:0] i_b_addr,
    input  wire logic [srmm_pkg::COL_W-1:0]  i_b_col,
    input  wire logic signed [srmm_pkg::VALUE_WIDTH-1:0] i_b_val,
    input  wire logic              i_q_empty,
    input  srmm_pkg::t_op          i_op,
    output logic                   o_pop,
    srmm_out_if.source             out_ch
);
    import srmm_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_MUL  = 6'b000100,
        S_ACC  = 6'b001000,
        S_SCAN = 6'b010000,
        S_CLR  = 6'b100000
    } t_state;

    logic signed [VALUE_WIDTH-1:0] r_bval_mem [MAX_NNZ];
    logic [COL_W-1:0]              r_bcol_mem [MAX_NNZ];
    logic signed [ACC_W-1:0]       r_acc_mem  [MAX_DIM];

    t_state                  r_st;
    t_op                     r_op;
    logic [CNT_W-1:0]        r_i;
    logic signed [VALUE_WIDTH-1:0] r_bv;
    logic [COL_W-1:0]        r_bc, r_mc;
    logic signed [PROD_W-1:0] r_prod;
    logic [DIM_W-1:0]        r_k;
    logic                    r_pend;
    t_out                    r_pd;
    logic                    r_ov;
    t_out                    r_out;
    logic                    r_acc_valid;
    logic signed [ACC_W-1:0] r_acc_rd;
    logic [ADDR_W-1:0]       rd_addr;
    logic [COL_W-1:0]        acc_ra;
    logic signed [ACC_W:0]   sum;
    logic signed [ACC_W-1:0] sat;
    logic                    out_free;
    logic [DIM_W-1:0]        nc;

    assign nc = (i_nc > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : i_nc;
    assign out_free = !r_ov || out_ch.ready;
    assign o_pop = (r_st == S_IDLE) && !i_q_empty;
    assign rd_addr = r_op.first + r_i[ADDR_W-1:0];
    assign sum = (ACC_W+1)'(r_acc_rd) + (ACC_W+1)'(r_prod);
    assign sat = (sum > (ACC_W+1)'(ACC_MAX)) ? ACC_MAX :
                 (sum < (ACC_W+1)'(ACC_MIN)) ? ACC_MIN : sum[ACC_W-1:0];
    // A stalled scan keeps re-reading slot r_k-1.
    assign acc_ra = (r_st == S_MUL) ? r_bc :
                    (r_st == S_SCAN && !out_free) ? r_k[COL_W-1:0] - 1'b1 :
                    r_k[COL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_b_we) begin
            r_bval_mem[i_b_addr] <= i_b_val;
            r_bcol_mem[i_b_addr] <= i_b_col;
        end
        r_bv <= r_bval_mem[rd_addr];
        r_bc <= r_bcol_mem[rd_addr];
    end

    // Accumulator: one read port, one write port.
    always_ff @(posedge i_clk) begin
        r_acc_rd <= r_acc_mem[acc_ra];
        if (r_st == S_ACC && {1'b0, r_mc} < nc) begin
            r_acc_mem[r_mc] <= sat;
        end else if (r_st == S_CLR) begin
            r_acc_mem[r_k[COL_W-1:0]] <= '0;
        end
        if (r_st == S_MUL) begin
            r_prod <= r_op.value * r_bv;
            r_mc   <= r_bc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR;
            r_k <= '0;
            r_i <= '0;
            r_ov <= 1'b0;
            r_pend <= 1'b0;
            r_acc_valid <= 1'b0;
        end else begin
            if (r_ov && out_ch.ready) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (o_pop) begin
                        r_op <= i_op;
                        r_i <= '0;
                        r_k <= '0;
                        r_pend <= 1'b0;
                        r_acc_valid <= 1'b0;
                        if (i_op.length != '0) r_st <= S_RD;
                        else if (i_op.emit) r_st <= S_SCAN;
                    end
                end
                S_RD: r_st <= S_MUL;
                S_MUL: r_st <= S_ACC;
                S_ACC: begin
                    r_i <= r_i + 1'b1;
                    if (r_i + 1'b1 != r_op.length) r_st <= S_RD;
                    else if (r_op.emit) r_st <= S_SCAN;
                    else r_st <= S_IDLE;
                end
                S_SCAN: begin
                    // r_acc_rd holds slot r_k-1 once r_acc_valid is set.
                    if (out_free) begin
                        if (r_acc_valid && r_acc_rd != '0) begin
                            if (r_pend) begin
                                r_out <= r_pd;
                                r_ov <= 1'b1;
                            end
                            r_pd.out_col <= r_k[COL_W-1:0] - 1'b1;
                            r_pd.out_value <= r_acc_rd;
                            r_pd.last_of_row <= 1'b0;
                            r_pd.row_empty <= 1'b0;
                            r_pd.overflow <= r_op.dropped;
                            r_pend <= 1'b1;
                        end
                        if (r_k == nc) begin
                            r_k <= '0;
                            r_st <= S_CLR;
                            if (!(r_acc_valid && r_acc_rd != '0)) begin
                                r_out <= '{out_col: r_pend ? r_pd.out_col : '0,
                                           out_value: r_pend ? r_pd.out_value : '0,
                                           last_of_row: 1'b1,
                                           row_empty: !r_pend,
                                           overflow: r_op.dropped};
                                r_ov <= 1'b1;
                                r_pend <= 1'b0;
                            end
                        end else begin
                            r_k <= r_k + 1'b1;
                            r_acc_valid <= 1'b1;
                        end
                    end
                end
                S_CLR: begin
                    if (r_pend) begin
                        if (out_free) begin
                            r_out <= '{out_col: r_pd.out_col,
                                       out_value: r_pd.out_value,
                                       last_of_row: 1'b1,
                                       row_empty: 1'b0,
                                       overflow: r_pd.overflow};
                            r_ov <= 1'b1;
                            r_pend <= 1'b0;
                        end
                    end else if (r_k == DIM_W'(MAX_DIM - 1)) begin
                        r_st <= S_IDLE;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid = r_ov;
    assign out_ch.data  = r_out;
endmodule
`default_nettype wire

### sv/sparse_row_matrix_multiply.sv
// Top level of the Gustavson row-wise sparse matrix multiply.
// Depends on srmm_pkg, srmm_if, srmm_front, srmm_queue, srmm_back.
//
//   channel   dir  payload
//   in_ch     in   func, row_index, col_index, value, row_end
//   out_ch    out  out_col, out_value, last_of_row, row_empty, overflow
//   cfg_ch    in   index, wdata (num_cols, num_b_rows)
//
// The front reads the directory for every item and then classifies it; a load ends
// there. An A nonzero then takes a back-end pop from idle plus, per stored B entry of
// its row, a store read, a multiply and an accumulator add. A row end adds a scan of
// the num_cols accumulator slots and a clear of all 64, which first sends the last
// result when the last column is nonzero. After reset the same clear runs once. Output
// stalls hold the scan; a 4-deep op queue lets the front keep taking items.
`timescale 1ns / 1ps
`default_nettype none
module sparse_row_matrix_multiply (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    srmm_in_if.sink   in_ch,
    srmm_out_if.source out_ch,
    srmm_cfg_if.sink  cfg_ch
);
    import srmm_pkg::*;

    logic [DIM_W-1:0] r_nc, r_nr;
    t_op   op_in, op_out;
    logic  push, pop, q_full, q_empty, b_we;
    logic [ADDR_W-1:0] b_addr;
    logic [COL_W-1:0]  b_col;
    logic signed [VALUE_WIDTH-1:0] b_val;

    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nc <= DIM_W'(MAX_DIM);
            r_nr <= DIM_W'(MAX_DIM);
        end else if (cfg_ch.valid) begin
            if (cfg_ch.index == REG_NUM_COLS) r_nc <= cfg_ch.wdata;
            if (cfg_ch.index == REG_NUM_B_ROWS) r_nr <= cfg_ch.wdata;
        end
    end

    srmm_front u_front (
        .i_clk, .i_rst_n, .in_ch,
        .i_nc(r_nc), .i_nr((r_nr > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_nr),
        .i_q_full(q_full), .o_op(op_in), .o_op_push(push),
        .o_b_we(b_we), .o_b_addr(b_addr), .o_b_col(b_col), .o_b_val(b_val)
    );

    srmm_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_op(op_in), .o_full(q_full),
        .i_pop(pop), .o_empty(q_empty), .o_op(op_out)
    );

    srmm_back u_back (
        .i_clk, .i_rst_n, .i_nc(r_nc),
        .i_b_we(b_we), .i_b_addr(b_addr), .i_b_col(b_col), .i_b_val(b_val),
        .i_q_empty(q_empty), .i_op(op_out), .o_pop(pop),
        .out_ch
    );
endmodule
`default_nettype wire

### sv/srmm_checker.sv
// Port-level checks on the sparse row matrix multiply, bound to the top level.
// Depends on srmm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srmm_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic out_valid,
    input wire logic out_ready,
    input srmm_pkg::t_out out_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped under stall");
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.row_empty |->
            out_data.last_of_row && out_data.out_value == '0 && out_data.out_col == '0)
        else $error("empty row carries data");
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_data.row_empty |-> out_data.out_value != '0)
        else $error("zero value emitted");
    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_ready && out_data.overflow |=>
            !out_valid || out_data.overflow)
        else $error("overflow flag fell");
endmodule

bind sparse_row_matrix_multiply srmm_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire
